### rtl/core/xalu_pkg.sv
// package for the x86 integer alu: operation codes, flag record, widths
// and small helper functions; no dependencies
`timescale 1ns / 1ps

package xalu_pkg;

    localparam int InWidth  = 80;
    localparam int OutWidth = 40;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBB  = 5'd3,
        OP_CMP  = 5'd4,
        OP_INC  = 5'd5,
        OP_DEC  = 5'd6,
        OP_NEG  = 5'd7,
        OP_AND  = 5'd8,
        OP_OR   = 5'd9,
        OP_XOR  = 5'd10,
        OP_TEST = 5'd11,
        OP_ROL  = 5'd12,
        OP_ROR  = 5'd13,
        OP_RCL  = 5'd14,
        OP_RCR  = 5'd15,
        OP_SHL  = 5'd16,
        OP_SHR  = 5'd17,
        OP_SAR  = 5'd18,
        OP_SHLD = 5'd19,
        OP_SHRD = 5'd20,
        OP_BSR  = 5'd21
    } op_t;

    typedef enum logic [1:0] {
        SZ_BYTE  = 2'd0,
        SZ_WORD  = 2'd1,
        SZ_DWORD = 2'd2
    } size_t;

    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } flags_t;

    typedef struct packed {
        logic [4:0]  action;
        logic [1:0]  size;
        logic [31:0] dest_value;
        logic [31:0] source_value;
        logic [4:0]  shift_count;
    } item_t;

    function automatic logic [31:0] size_mask(input logic [1:0] sz);
        case (sz)
            SZ_BYTE: size_mask = 32'h0000_00ff;
            SZ_WORD: size_mask = 32'h0000_ffff;
            default: size_mask = 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic msb(input logic [31:0] x, input logic [1:0] sz);
        case (sz)
            SZ_BYTE: msb = x[7];
            SZ_WORD: msb = x[15];
            default: msb = x[31];
        endcase
    endfunction

    function automatic logic msb_next(input logic [31:0] x, input logic [1:0] sz);
        case (sz)
            SZ_BYTE: msb_next = x[6];
            SZ_WORD: msb_next = x[14];
            default: msb_next = x[30];
        endcase
    endfunction

    function automatic logic carry_at(input logic [63:0] x, input logic [1:0] sz);
        case (sz)
            SZ_BYTE: carry_at = x[8];
            SZ_WORD: carry_at = x[16];
            default: carry_at = x[32];
        endcase
    endfunction

endpackage

### rtl/core/x86_integer_alu_with_flags_unit.sv
// x86 integer alu: input register, execute logic, result register, kept flags
// depends on xalu_pkg and xalu_exec
// an item passes the input register and then the result register before its result is valid
// throughput: one transaction per cycle while m_tready holds; the flags register feeds the next item directly
// a waiting result blocks input only once the input register also holds an item
// reset: both stages empty, all six flags cleared
`timescale 1ns / 1ps

module x86_integer_alu_with_flags_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action[4:0], size[6:5], dest_value[38:7], source_value[70:39],
    // shift_count[75:71], zero pad [79:76]
    input  logic [xalu_pkg::InWidth-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result[31:0], carry_flag[32], parity_flag[33], adjust_flag[34],
    // zero_flag[35], sign_flag[36], overflow_flag[37], zero pad [39:38]
    output logic [xalu_pkg::OutWidth-1:0]  m_tdata
);
    import xalu_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [31:0] out_result_reg;
    flags_t      out_flags_reg;
    flags_t      flags_reg;
    logic        advance;
    logic [31:0] exec_result;
    flags_t      exec_flags;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    xalu_exec u_exec (
        .action       (in_item_reg.action),
        .size         (in_item_reg.size),
        .dest_value   (in_item_reg.dest_value),
        .source_value (in_item_reg.source_value),
        .shift_count  (in_item_reg.shift_count),
        .flags_in     (flags_reg),
        .result       (exec_result),
        .flags_out    (exec_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= exec_flags;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.action       <= s_tdata[4:0];
            in_item_reg.size         <= s_tdata[6:5];
            in_item_reg.dest_value   <= s_tdata[38:7];
            in_item_reg.source_value <= s_tdata[70:39];
            in_item_reg.shift_count  <= s_tdata[75:71];
        end
        if (advance)
        begin
            out_result_reg <= exec_result;
            out_flags_reg  <= exec_flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_flags_reg.of, out_flags_reg.sf, out_flags_reg.zf,
                       out_flags_reg.af, out_flags_reg.pf, out_flags_reg.cf, out_result_reg};

endmodule

### rtl/core/xalu_exec.sv
// combinational execute logic of the x86 integer alu: result and new flags
// depends on xalu_pkg
`timescale 1ns / 1ps

module xalu_exec (
    input  logic [4:0]       action,
    input  logic [1:0]       size,
    input  logic [31:0]      dest_value,
    input  logic [31:0]      source_value,
    input  logic [4:0]       shift_count,
    input  xalu_pkg::flags_t flags_in,
    output logic [31:0]      result,
    output xalu_pkg::flags_t flags_out
);
    import xalu_pkg::*;

    always_comb
    begin
        logic [31:0]  m;
        logic [31:0]  d;
        logic [31:0]  s;
        logic [31:0]  r;
        logic [32:0]  sum;
        logic [63:0]  w64;
        logic [4:0]   c;
        logic [4:0]   krc;
        logic [3:0]   k4;
        logic         cin;
        logic         cfn;
        logic         ofn;
        logic         szp;
        logic [15:0]  t16;
        logic [31:0]  t32;
        logic [63:0]  t64;
        logic [127:0] t128;
        logic [17:0]  t18;
        logic [33:0]  t34;
        logic [65:0]  t66;
        logic [8:0]   x9;
        logic [16:0]  x17;
        logic [32:0]  x33;
        logic [4:0]   idx;
        flags_t       f;

        m    = size_mask(size);
        d    = dest_value & m;
        s    = source_value & m;
        c    = shift_count;
        f    = flags_in;
        r    = d;
        sum  = '0;
        w64  = '0;
        cin  = 1'b0;
        cfn  = 1'b0;
        ofn  = 1'b0;
        szp  = 1'b0;
        krc  = '0;
        k4   = '0;
        t16  = '0;
        t32  = '0;
        t64  = '0;
        t128 = '0;
        t18  = '0;
        t34  = '0;
        t66  = '0;
        x9   = '0;
        x17  = '0;
        x33  = '0;
        idx  = '0;

        case (op_t'(action))
            OP_ADD, OP_ADC:
            begin
                cin  = (op_t'(action) == OP_ADC) ? flags_in.cf : 1'b0;
                sum  = {1'b0, d} + {1'b0, s} + {32'd0, cin};
                r    = sum[31:0] & m;
                szp  = 1'b1;
                f.cf = carry_at({31'd0, sum}, size);
                f.af = d[4] ^ s[4] ^ r[4];
                f.of = msb((d ^ r) & (s ^ r), size);
            end
            OP_SUB, OP_SBB, OP_CMP:
            begin
                cin  = (op_t'(action) == OP_SBB) ? flags_in.cf : 1'b0;
                sum  = {1'b0, d} - {1'b0, s} - {32'd0, cin};
                r    = sum[31:0] & m;
                szp  = 1'b1;
                f.cf = sum[32];
                f.af = d[4] ^ s[4] ^ r[4];
                f.of = msb((d ^ s) & (d ^ r), size);
            end
            OP_INC, OP_DEC:
            begin
                r    = ((op_t'(action) == OP_INC) ? d + 32'd1 : d - 32'd1) & m;
                szp  = 1'b1;
                f.af = d[4] ^ r[4];
                f.of = (op_t'(action) == OP_INC) ? (msb(r, size) && ((r & ~m) == 32'd0)
                        && (((r << 1) & m) == 32'd0))
                     : (msb(d, size) && (((d << 1) & m) == 32'd0));
            end
            OP_NEG:
            begin
                r    = (32'd0 - d) & m;
                szp  = 1'b1;
                f.cf = (d != 32'd0);
                f.af = d[4] ^ r[4];
                f.of = msb(d, size) && (((d << 1) & m) == 32'd0);
            end
            OP_AND, OP_OR, OP_XOR, OP_TEST:
            begin
                case (op_t'(action))
                    OP_OR:   r = d | s;
                    OP_XOR:  r = d ^ s;
                    default: r = d & s;
                endcase
                szp  = 1'b1;
                f.cf = 1'b0;
                f.af = 1'b0;
                f.of = 1'b0;
            end
            OP_ROL, OP_ROR:
            begin
                if (c != 5'd0)
                begin
                    case (size)
                        SZ_BYTE:
                        begin
                            t16 = (op_t'(action) == OP_ROL) ? ({d[7:0], d[7:0]} << c[2:0])
                                                            : ({d[7:0], d[7:0]} >> c[2:0]);
                            r = (op_t'(action) == OP_ROL) ? {24'd0, t16[15:8]}
                                                          : {24'd0, t16[7:0]};
                        end
                        SZ_WORD:
                        begin
                            t32 = (op_t'(action) == OP_ROL) ? ({d[15:0], d[15:0]} << c[3:0])
                                                            : ({d[15:0], d[15:0]} >> c[3:0]);
                            r = (op_t'(action) == OP_ROL) ? {16'd0, t32[31:16]}
                                                          : {16'd0, t32[15:0]};
                        end
                        default:
                        begin
                            t64 = (op_t'(action) == OP_ROL) ? ({d, d} << c) : ({d, d} >> c);
                            r = (op_t'(action) == OP_ROL) ? t64[63:32] : t64[31:0];
                        end
                    endcase
                    if (op_t'(action) == OP_ROL)
                    begin
                        f.cf = r[0];
                        f.of = msb(r, size) ^ r[0];
                    end
                    else
                    begin
                        f.cf = msb(r, size);
                        f.of = msb(r, size) ^ msb_next(r, size);
                    end
                end
            end
            OP_RCL, OP_RCR:
            begin
                // rotate through carry, count taken modulo w+1 at narrow sizes
                case (size)
                    SZ_BYTE:
                        krc = (c >= 5'd27) ? c - 5'd27 : (c >= 5'd18) ? c - 5'd18
                            : (c >= 5'd9) ? c - 5'd9 : c;
                    SZ_WORD:
                        krc = (c >= 5'd17) ? c - 5'd17 : c;
                    default:
                        krc = c;
                endcase
                if (krc != 5'd0)
                begin
                    case (size)
                        SZ_BYTE:
                        begin
                            x9 = {flags_in.cf, d[7:0]};
                            t18 = (op_t'(action) == OP_RCL) ? ({x9, x9} << krc)
                                                            : ({x9, x9} >> krc);
                            x9 = (op_t'(action) == OP_RCL) ? t18[17:9] : t18[8:0];
                            r = {24'd0, x9[7:0]};
                            cfn = x9[8];
                        end
                        SZ_WORD:
                        begin
                            x17 = {flags_in.cf, d[15:0]};
                            t34 = (op_t'(action) == OP_RCL) ? ({x17, x17} << krc)
                                                            : ({x17, x17} >> krc);
                            x17 = (op_t'(action) == OP_RCL) ? t34[33:17] : t34[16:0];
                            r = {16'd0, x17[15:0]};
                            cfn = x17[16];
                        end
                        default:
                        begin
                            x33 = {flags_in.cf, d};
                            t66 = (op_t'(action) == OP_RCL) ? ({x33, x33} << krc)
                                                            : ({x33, x33} >> krc);
                            x33 = (op_t'(action) == OP_RCL) ? t66[65:33] : t66[32:0];
                            r = x33[31:0];
                            cfn = x33[32];
                        end
                    endcase
                    f.cf = cfn;
                    f.of = (op_t'(action) == OP_RCL) ? (msb(r, size) ^ cfn)
                                                     : (msb(r, size) ^ msb_next(r, size));
                end
            end
            OP_SHL, OP_SHR, OP_SAR:
            begin
                if (c != 5'd0)
                begin
                    case (op_t'(action))
                        OP_SHL:
                        begin
                            w64 = {32'd0, d} << c;
                            r   = w64[31:0] & m;
                            cfn = carry_at(w64, size);
                            ofn = msb(r, size) ^ cfn;
                        end
                        OP_SHR:
                        begin
                            r   = d >> c;
                            t32 = d >> (c - 5'd1);
                            cfn = t32[0];
                            ofn = msb(d, size);
                        end
                        default:
                        begin
                            // sign fill above the operand width
                            w64 = {32'd0, d} | (msb(d, size) ? ~{32'd0, m} : 64'd0);
                            t64 = w64 >> c;
                            r   = t64[31:0] & m;
                            t64 = w64 >> (c - 5'd1);
                            cfn = t64[0];
                            ofn = 1'b0;
                        end
                    endcase
                    szp  = 1'b1;
                    f.cf = cfn;
                    f.af = 1'b0;
                    f.of = ofn;
                end
            end
            OP_SHLD, OP_SHRD:
            begin
                if (c != 5'd0)
                begin
                    case (size)
                        SZ_BYTE:
                        begin
                            k4 = c[3:0];
                            if (op_t'(action) == OP_SHLD)
                            begin
                                t16 = {d[7:0], s[7:0]};
                                t32 = {t16, t16} << k4;
                                r   = {24'd0, t32[31:24]};
                                cfn = t32[16];
                            end
                            else
                            begin
                                t16 = {s[7:0], d[7:0]};
                                t32 = {t16, t16} >> k4;
                                r   = {24'd0, t32[7:0]};
                                cfn = t32[15];
                            end
                        end
                        SZ_WORD:
                        begin
                            if (op_t'(action) == OP_SHLD)
                            begin
                                t32 = {d[15:0], s[15:0]};
                                t64 = {t32, t32} << c;
                                r   = {16'd0, t64[63:48]};
                                cfn = t64[32];
                            end
                            else
                            begin
                                t32 = {s[15:0], d[15:0]};
                                t64 = {t32, t32} >> c;
                                r   = {16'd0, t64[15:0]};
                                cfn = t64[31];
                            end
                        end
                        default:
                        begin
                            if (op_t'(action) == OP_SHLD)
                            begin
                                t128 = {d, s, d, s} << c;
                                r    = t128[127:96];
                                cfn  = t128[64];
                            end
                            else
                            begin
                                t128 = {s, d, s, d} >> c;
                                r    = t128[31:0];
                                cfn  = t128[63];
                            end
                        end
                    endcase
                    szp  = 1'b1;
                    f.cf = cfn;
                    f.af = 1'b0;
                    f.of = msb(r ^ d, size);
                end
            end
            OP_BSR:
            begin
                if (s == 32'd0)
                begin
                    f.zf = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 32; i++)
                    begin
                        if (s[i])
                            idx = 5'(i);
                    end
                    r    = {27'd0, idx};
                    f.zf = 1'b0;
                end
            end
            default:
            begin
                r = d;
            end
        endcase

        if (szp)
        begin
            f.pf = ~^r[7:0];
            f.zf = (r == 32'd0);
            f.sf = msb(r, size);
        end

        result    = r & m;
        flags_out = f;
    end

endmodule

### rtl/core/xalu_checker.sv
// port-level checks for the x86 integer alu, bound to the top level
// depends on x86_integer_alu_with_flags_unit
`timescale 1ns / 1ps

module xalu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // an empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // every input transaction must be followed by a valid result once it has passed the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result missing after input transaction");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:38] == 2'b00)
        else $error("nonzero padding in result");

endmodule

bind x86_integer_alu_with_flags_unit xalu_checker u_xalu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
